FILE: hdl/dtcmb_pkg.sv
package dtcmb_pkg;

  typedef enum logic [2:0] {
    CMD_ACTIVATE      = 3'd0,
    CMD_DEACTIVATE    = 3'd1,
    CMD_CLEAR_PREV    = 3'd2,
    CMD_READ_ACTIVE   = 3'd3,
    CMD_READ_PREVIOUS = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_FIND_END,
    ST_DECIDE,
    ST_RESP,
    ST_RD_HDR,
    ST_RD_SCAN,
    ST_RD_EMIT,
    ST_RD_PAD,
    ST_RD_FLUSH
  } state_e;

  localparam int unsigned SpnW   = 19;
  localparam int unsigned FmiW   = 5;
  localparam int unsigned OccW   = 16;
  localparam int unsigned ByteW  = 8;

  localparam logic [OccW-1:0]  OccMax    = 16'hFFFF;
  localparam logic [ByteW-1:0] ByteFill  = 8'hFF;
  localparam logic [ByteW-1:0] ByteCnSat = 8'h7F;

  // One table entry as stored in the entry memory.
  typedef struct packed {
    logic [OccW-1:0] count;
    logic [FmiW-1:0] mode;
    logic [SpnW-1:0] suspect;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

FILE: hdl/dtcmb_ram.sv
module dtcmb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/dtc_table_dm_message_builder_top.sv
// Channel    | Direction | tdata (lowest bit first)                 | Side bands
// s_axis     | in        | suspect_number[18:0], failure_mode[4:0]  | tuser: command
// m_axis     | out       | message_byte[7:0], occurrence_count[15:0] | tlast: last
//
// One command is worked on at a time. Activate and deactivate scan the entry
// memory one entry per cycle. A list read steps over unlisted entries one entry
// per cycle, reads each listed code from the memory and sends its four bytes.
// Reset clears the valid and active marks at once; the entry memory needs no
// clearing pass.
// The output register holds one result; each byte of a read is held back in a
// pending register so that tlast is known. A stalled m_axis simply pauses the sequencer.
module dtc_table_dm_message_builder_top #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned MAX_ACTIVE    = 8,
  parameter int unsigned MAX_PREVIOUS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // suspect_number[18:0], failure_mode[23:19]
  input  logic [2:0]  s_axis_tuser,  // command[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // message_byte[7:0], occurrence_count[23:8]
  output logic        m_axis_tlast   // last
);

  import dtcmb_pkg::*;

  localparam int unsigned IdxW   = $clog2(TABLE_ENTRIES);
  localparam int unsigned PtrW   = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CntTop = (TABLE_ENTRIES > 15) ? TABLE_ENTRIES : 15;
  localparam int unsigned CntW   = $clog2(CntTop + 1);

  state_e             state_q, state_d;
  cmd_e               cmd_q, cmd_d;
  logic [SpnW-1:0]    spn_q, spn_d;
  logic [FmiW-1:0]    fmi_q, fmi_d;
  logic [PtrW-1:0]    ptr_q, ptr_d;
  logic               chk_vld_q, chk_vld_d;
  logic [IdxW-1:0]    chk_idx_q, chk_idx_d;
  logic               hit_q, hit_d;
  logic [IdxW-1:0]    hit_idx_q, hit_idx_d;
  logic [OccW-1:0]    hit_cnt_q, hit_cnt_d;
  logic               free_q, free_d;
  logic [IdxW-1:0]    free_idx_q, free_idx_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [TABLE_ENTRIES-1:0] active_q, active_d;
  logic [CntW-1:0]    act_cnt_q, act_cnt_d;
  logic [CntW-1:0]    prev_cnt_q, prev_cnt_d;
  logic [CntW-1:0]    listed_q, listed_d;
  logic [2:0]         sub_q, sub_d;
  logic [OccW-1:0]    res_cnt_q, res_cnt_d;
  logic               pend_valid_q, pend_valid_d;
  logic [ByteW-1:0]   pend_byte_q, pend_byte_d;
  logic               out_valid_q, out_valid_d;
  logic [ByteW-1:0]   out_byte_q, out_byte_d;
  logic [OccW-1:0]    out_cnt_q, out_cnt_d;
  logic               out_last_q, out_last_d;

  logic               ram_we, ram_re;
  logic [IdxW-1:0]    ram_waddr, ram_raddr;
  entry_t             ram_wdata, ram_rdata;
  logic [EntryW-1:0]  ram_rdata_raw;

  logic               out_free;
  logic               emit_en, emit_go;
  logic [ByteW-1:0]   emit_byte;
  logic [IdxW-1:0]    ptr_idx;
  logic               want_active;
  logic [CntW-1:0]    list_limit;
  logic [OccW-1:0]    inc_cnt;

  dtcmb_ram #(
    .WIDTH(EntryW),
    .DEPTH(TABLE_ENTRIES)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  assign out_free    = !out_valid_q || m_axis_tready;
  assign ptr_idx     = ptr_q[IdxW-1:0];
  assign want_active = (cmd_q == CMD_READ_ACTIVE);
  assign list_limit  = want_active ? CntW'(MAX_ACTIVE) : CntW'(MAX_PREVIOUS);
  assign inc_cnt     = (hit_cnt_q == OccMax) ? hit_cnt_q : hit_cnt_q + 1'b1;
  assign emit_go     = emit_en && (!pend_valid_q || out_free);
  assign ram_raddr   = ptr_idx;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    spn_d        = spn_q;
    fmi_d        = fmi_q;
    ptr_d        = ptr_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_cnt_d    = hit_cnt_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    valid_d      = valid_q;
    active_d     = active_q;
    act_cnt_d    = act_cnt_q;
    prev_cnt_d   = prev_cnt_q;
    listed_d     = listed_q;
    sub_d        = sub_q;
    res_cnt_d    = res_cnt_q;
    pend_valid_d = pend_valid_q;
    pend_byte_d  = pend_byte_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_byte_d   = out_byte_q;
    out_cnt_d    = out_cnt_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = hit_idx_q;
    ram_wdata    = '{count: hit_cnt_q, mode: fmi_q, suspect: spn_q};
    emit_en      = 1'b0;
    emit_byte    = ByteFill;

    // Compare stage of the table scan: data read in the previous cycle.
    if (chk_vld_q && valid_q[chk_idx_q] && ram_rdata.suspect == spn_q &&
        ram_rdata.mode == fmi_q) begin
      hit_d     = 1'b1;
      hit_idx_d = chk_idx_q;
      hit_cnt_d = ram_rdata.count;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          spn_d    = s_axis_tdata[SpnW-1:0];
          fmi_d    = s_axis_tdata[SpnW+FmiW-1:SpnW];
          ptr_d    = '0;
          hit_d    = 1'b0;
          free_d   = 1'b0;
          listed_d = '0;
          sub_d    = '0;
          priority case (s_axis_tuser)
            CMD_ACTIVATE: begin
              cmd_d   = CMD_ACTIVATE;
              state_d = ST_FIND;
            end
            CMD_DEACTIVATE: begin
              cmd_d   = CMD_DEACTIVATE;
              state_d = ST_FIND;
            end
            CMD_CLEAR_PREV: begin
              cmd_d      = CMD_CLEAR_PREV;
              valid_d    = valid_q & active_q;
              prev_cnt_d = '0;
              res_cnt_d  = '0;
              state_d    = ST_RESP;
            end
            CMD_READ_ACTIVE: begin
              cmd_d   = CMD_READ_ACTIVE;
              state_d = ST_RD_HDR;
            end
            CMD_READ_PREVIOUS: begin
              cmd_d   = CMD_READ_PREVIOUS;
              state_d = ST_RD_HDR;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_FIND: begin
        ram_re    = 1'b1;
        chk_vld_d = 1'b1;
        chk_idx_d = ptr_idx;
        if (!free_q && !valid_q[ptr_idx]) begin
          free_d     = 1'b1;
          free_idx_d = ptr_idx;
        end
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == PtrW'(TABLE_ENTRIES - 1)) begin
          state_d = ST_FIND_END;
        end
      end

      ST_FIND_END: begin
        state_d = ST_DECIDE;
      end

      ST_DECIDE: begin
        res_cnt_d = '0;
        state_d   = ST_RESP;
        if (cmd_q == CMD_ACTIVATE) begin
          if (hit_q && active_q[hit_idx_q]) begin
            res_cnt_d = hit_cnt_q;
          end else if (act_cnt_q >= CntW'(MAX_ACTIVE)) begin
            res_cnt_d = '0;
          end else if (hit_q) begin
            // A previously active code comes back.
            ram_we              = 1'b1;
            ram_wdata.count     = inc_cnt;
            active_d[hit_idx_q] = 1'b1;
            act_cnt_d           = act_cnt_q + 1'b1;
            prev_cnt_d          = prev_cnt_q - 1'b1;
            res_cnt_d           = inc_cnt;
          end else if (free_q) begin
            ram_we               = 1'b1;
            ram_waddr            = free_idx_q;
            ram_wdata.count      = OccW'(1);
            valid_d[free_idx_q]  = 1'b1;
            active_d[free_idx_q] = 1'b1;
            act_cnt_d            = act_cnt_q + 1'b1;
            res_cnt_d            = OccW'(1);
          end
        end else if (hit_q) begin
          if (!active_q[hit_idx_q]) begin
            res_cnt_d = hit_cnt_q;
          end else if (prev_cnt_q < CntW'(MAX_PREVIOUS)) begin
            active_d[hit_idx_q] = 1'b0;
            act_cnt_d           = act_cnt_q - 1'b1;
            prev_cnt_d          = prev_cnt_q + 1'b1;
            res_cnt_d           = hit_cnt_q;
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = '0;
          out_cnt_d   = res_cnt_q;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_RD_HDR: begin
        emit_en   = 1'b1;
        emit_byte = ByteFill;
        if (emit_go) begin
          sub_d = sub_q + 1'b1;
          if (sub_q == 3'd1) begin
            state_d = ST_RD_SCAN;
          end
        end
      end

      ST_RD_SCAN: begin
        if (ptr_q == PtrW'(TABLE_ENTRIES) || listed_q == list_limit) begin
          if (listed_q == '0) begin
            sub_d   = 3'd0;
            state_d = ST_RD_PAD;
          end else if (listed_q == CntW'(1)) begin
            sub_d   = 3'd4;
            state_d = ST_RD_PAD;
          end else begin
            state_d = ST_RD_FLUSH;
          end
        end else if (valid_q[ptr_idx] && active_q[ptr_idx] == want_active) begin
          ram_re  = 1'b1;
          sub_d   = '0;
          state_d = ST_RD_EMIT;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      ST_RD_EMIT: begin
        emit_en = 1'b1;
        unique case (sub_q[1:0])
          2'd0: emit_byte = ram_rdata.suspect[7:0];
          2'd1: emit_byte = ram_rdata.suspect[15:8];
          2'd2: emit_byte = {ram_rdata.suspect[18:16], ram_rdata.mode};
          default: begin
            emit_byte = (ram_rdata.count < OccW'(ByteCnSat)) ?
                        ram_rdata.count[ByteW-1:0] : ByteCnSat;
          end
        endcase
        if (emit_go) begin
          sub_d = sub_q + 1'b1;
          if (sub_q == 3'd3) begin
            listed_d = listed_q + 1'b1;
            ptr_d    = ptr_q + 1'b1;
            state_d  = ST_RD_SCAN;
          end
        end
      end

      ST_RD_PAD: begin
        emit_en   = 1'b1;
        emit_byte = (sub_q < 3'd4) ? '0 : ByteFill;
        if (emit_go) begin
          sub_d = sub_q + 1'b1;
          if (sub_q == 3'd5) begin
            state_d = ST_RD_FLUSH;
          end
        end
      end

      ST_RD_FLUSH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_byte_d   = pend_byte_q;
          out_cnt_d    = '0;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Each new byte of a list pushes the one held before it to the output.
    if (emit_go) begin
      pend_valid_d = 1'b1;
      pend_byte_d  = emit_byte;
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_byte_d  = pend_byte_q;
        out_cnt_d   = '0;
        out_last_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cmd_q        <= CMD_ACTIVATE;
      spn_q        <= '0;
      fmi_q        <= '0;
      ptr_q        <= '0;
      chk_vld_q    <= 1'b0;
      chk_idx_q    <= '0;
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      hit_cnt_q    <= '0;
      free_q       <= 1'b0;
      free_idx_q   <= '0;
      valid_q      <= '0;
      active_q     <= '0;
      act_cnt_q    <= '0;
      prev_cnt_q   <= '0;
      listed_q     <= '0;
      sub_q        <= '0;
      res_cnt_q    <= '0;
      pend_valid_q <= 1'b0;
      pend_byte_q  <= '0;
      out_valid_q  <= 1'b0;
      out_byte_q   <= '0;
      out_cnt_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      spn_q        <= spn_d;
      fmi_q        <= fmi_d;
      ptr_q        <= ptr_d;
      chk_vld_q    <= chk_vld_d;
      chk_idx_q    <= chk_idx_d;
      hit_q        <= hit_d;
      hit_idx_q    <= hit_idx_d;
      hit_cnt_q    <= hit_cnt_d;
      free_q       <= free_d;
      free_idx_q   <= free_idx_d;
      valid_q      <= valid_d;
      active_q     <= active_d;
      act_cnt_q    <= act_cnt_d;
      prev_cnt_q   <= prev_cnt_d;
      listed_q     <= listed_d;
      sub_q        <= sub_d;
      res_cnt_q    <= res_cnt_d;
      pend_valid_q <= pend_valid_d;
      pend_byte_q  <= pend_byte_d;
      out_valid_q  <= out_valid_d;
      out_byte_q   <= out_byte_d;
      out_cnt_q    <= out_cnt_d;
      out_last_q   <= out_last_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_cnt_q, out_byte_q};
  assign m_axis_tlast  = out_last_q;

endmodule
